@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is active.
`define SSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is active.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ssd_pkg.sv @@
package ssd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;
    localparam int KIND_W = 2;

    // Line codes
    localparam logic [BYTE_W-1:0] FRAME_END      = 8'hC0;
    localparam logic [BYTE_W-1:0] FRAME_ESC      = 8'hDB;
    localparam logic [BYTE_W-1:0] ESC_FOR_END    = 8'hDC;
    localparam logic [BYTE_W-1:0] ESC_FOR_ESC    = 8'hDD;
    localparam logic [BYTE_W-1:0] CTRL_SEL_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] CTRL_SEL_VALUE = 8'h80;
    localparam logic [BYTE_W-1:0] CTRL_KEEP_MASK = 8'h7F;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 11'd1500;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

    // Operations handed from the classifier to the frame engine
    typedef enum logic [1:0] {
        OP_DATA,
        OP_END,
        OP_BAD
    } op_code_t;

    typedef struct packed {
        op_code_t          op;
        logic [BYTE_W-1:0] data;
    } ssd_op_t;

endpackage

@@ rtl/ssd_if.sv @@
// Input byte channel
interface ssd_in_if;
    logic                      valid;
    logic                      ready;
    logic [ssd_pkg::BYTE_W-1:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink   (input valid, input line_byte, output ready);
endinterface

// Result channel
interface ssd_out_if;
    logic                      valid;
    logic                      ready;
    logic [ssd_pkg::KIND_W-1:0] kind;
    logic [ssd_pkg::BYTE_W-1:0] data_byte;
    logic [ssd_pkg::LEN_W-1:0]  frame_len;

    modport source (output valid, output kind, output data_byte, output frame_len,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_len,
                    output ready);
endinterface

// Configuration write channel
interface ssd_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [ssd_pkg::LEN_W-1:0] max_frame_len;

    modport source (output valid, output max_frame_len, input ready);
    modport sink   (input valid, input max_frame_len, output ready);
endinterface

@@ rtl/ssd_front.sv @@
module ssd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [ssd_pkg::BYTE_W-1:0] line_byte,
    output logic                       push,
    output ssd_pkg::ssd_op_t           push_entry
);
    import ssd_pkg::*;

    logic escape_pending_reg;
    logic escape_pending_next;

    // Classify one line byte
    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        push                = 1'b0;
        push_entry.op       = OP_DATA;
        push_entry.data     = line_byte;
        if (accept)
        begin
            if (escape_pending_reg)
            begin
                escape_pending_next = 1'b0;
                push                = 1'b1;
                if (line_byte == ESC_FOR_END)
                begin
                    push_entry.data = FRAME_END;
                end
                else if (line_byte == ESC_FOR_ESC)
                begin
                    push_entry.data = FRAME_ESC;
                end
                else if ((line_byte & CTRL_SEL_MASK) == CTRL_SEL_VALUE)
                begin
                    push_entry.data = line_byte & CTRL_KEEP_MASK;
                end
                else
                begin
                    push_entry.op = OP_BAD;
                end
            end
            else if (line_byte == FRAME_END)
            begin
                push          = 1'b1;
                push_entry.op = OP_END;
            end
            else if (line_byte == FRAME_ESC)
            begin
                // escape byte itself causes nothing downstream
                escape_pending_next = 1'b1;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
        end
        else
        begin
            escape_pending_reg <= escape_pending_next;
        end
    end

endmodule

@@ rtl/ssd_queue.sv @@
module ssd_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ssd_pkg::ssd_op_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output ssd_pkg::ssd_op_t head_entry
);
    import ssd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ssd_op_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/ssd_back.sv @@
module ssd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  ssd_pkg::ssd_op_t          head_entry,
    output logic                      pop,
    input  logic [ssd_pkg::LEN_W-1:0] max_len,
    ssd_out_if.source                 tx
);
    import ssd_pkg::*;

    logic               frame_bad_reg, frame_bad_next;
    logic [LEN_W-1:0]   byte_count_reg, byte_count_next;
    logic               bytes_emitted_reg, bytes_emitted_next;
    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               emit;

    // Take the next operation whenever the output slot is free or draining
    assign pop = head_valid && (!out_valid_reg || tx.ready);

    // Frame state and result selection
    always_comb
    begin
        frame_bad_next     = frame_bad_reg;
        byte_count_next    = byte_count_reg;
        bytes_emitted_next = bytes_emitted_reg;
        emit               = 1'b0;
        kind_next          = KIND_DATA;
        data_next          = '0;
        len_next           = '0;
        if (pop)
        begin
            unique case (head_entry.op)
                OP_DATA:
                begin
                    if (!frame_bad_reg)
                    begin
                        if (byte_count_reg >= max_len)
                        begin
                            // overlong frame
                            frame_bad_next  = 1'b1;
                            byte_count_next = '0;
                        end
                        else
                        begin
                            byte_count_next    = byte_count_reg + LEN_W'(1);
                            bytes_emitted_next = 1'b1;
                            emit               = 1'b1;
                            data_next          = head_entry.data;
                        end
                    end
                end
                OP_BAD:
                begin
                    frame_bad_next  = 1'b1;
                    byte_count_next = '0;
                end
                OP_END:
                begin
                    if (frame_bad_reg)
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_DROPPED;
                    end
                    else if (bytes_emitted_reg && byte_count_reg != '0)
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_GOOD;
                        len_next  = byte_count_reg;
                    end
                    frame_bad_next     = 1'b0;
                    byte_count_next    = '0;
                    bytes_emitted_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        out_valid_next = emit ? 1'b1 : (out_valid_reg && !tx.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bad_reg     <= 1'b0;
            byte_count_reg    <= '0;
            bytes_emitted_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            frame_bad_reg     <= frame_bad_next;
            byte_count_reg    <= byte_count_next;
            bytes_emitted_reg <= bytes_emitted_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            len_reg  <= len_next;
        end
    end

    assign tx.valid     = out_valid_reg;
    assign tx.kind      = kind_reg;
    assign tx.data_byte = data_reg;
    assign tx.frame_len = len_reg;

endmodule

@@ rtl/slip_style_deframer.sv @@
// Channel | Dir | Payload                         | Note
// rx      | in  | line_byte[7:0]                  | raw serial bytes
// tx      | out | kind[1:0] data_byte[7:0] frame_len[10:0] | zero or one per byte
// cfg     | in  | max_frame_len[10:0]             | always ready
//
// One byte per cycle while the op queue is not full; a result is valid on tx once
// the classifier has written its op into the op queue and the frame engine has
// filled the output register from the queue head.
// Reset clears the escape flag, frame state, queue and output valid; the
// length limit returns to 1500. rx stalls only when the op queue is full; while
// streaming the queue already holds one op, so tx ready low fills it at the default depth.
`include "assert_macros.svh"

module slip_style_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    ssd_in_if.sink    rx,
    ssd_out_if.source tx,
    ssd_cfg_if.sink   cfg
);
    import ssd_pkg::*;

    logic             max_len_reg;
    logic [LEN_W-1:0] max_len_q_reg;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_head_valid;
    ssd_op_t          q_push_entry;
    ssd_op_t          q_head_entry;

    // Length limit register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_q_reg <= MAX_LEN_RESET;
            max_len_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                max_len_q_reg <= cfg.max_frame_len;
            end
            max_len_reg <= cfg.valid;
        end
    end

    assign rx.ready = !q_full;

    ssd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (rx.valid && rx.ready),
        .line_byte  (rx.line_byte),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    ssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    ssd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .max_len    (max_len_q_reg),
        .tx         (tx)
    );

    // Checks
    `SSD_ASSERT_IMPL(a_good_len, clk, rst_n, tx.valid && tx.kind == KIND_GOOD && !max_len_reg, tx.frame_len != '0 && tx.frame_len <= max_len_q_reg)
    `SSD_ASSERT_IMPL(a_marker_no_data, clk, rst_n, tx.valid && tx.kind != KIND_DATA, tx.data_byte == '0)
    `SSD_ASSERT_IMPL(a_len_only_good, clk, rst_n, tx.valid && tx.kind != KIND_GOOD, tx.frame_len == '0)
    `SSD_ASSERT_NEXT(a_tx_hold, clk, rst_n, tx.valid && !tx.ready, tx.valid && $stable({tx.kind, tx.data_byte, tx.frame_len}))

endmodule
